// ===== design/bitmap_range_allocator_top_defines.svh =====
// Assertion macros for the bitmap range allocator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BITMAP_RANGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_RANGE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bra_pkg.sv =====
// Shared types and codes for the bitmap range allocator.
// Used by bra_ctrl, bra_dp, the top level and the checker; no dependencies.
package bra_pkg;

  localparam int SLOTS_DEF  = 1024;
  localparam int WORD       = 32;

  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 11;
  localparam int SLOT_W     = 10;
  localparam int LEN_W      = 11;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE   = 2'd1;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SIZE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADIDX  = 2'd2;

  // word scanner operations
  localparam logic [2:0] OP_INIT     = 3'd0;
  localparam logic [2:0] OP_NEXT_SET = 3'd1;
  localparam logic [2:0] OP_NEXT_CLR = 3'd2;
  localparam logic [2:0] OP_HEAD     = 3'd3;
  localparam logic [2:0] OP_RUN      = 3'd4;
  localparam logic [2:0] OP_FREE     = 3'd5;
  localparam logic [2:0] OP_FILL     = 3'd6;
  localparam logic [2:0] OP_DOWN     = 3'd7;

  // result register loads
  localparam logic [2:0] RES_NONE    = 3'd0;
  localparam logic [2:0] RES_ALLOC   = 3'd1;
  localparam logic [2:0] RES_NOSPACE = 3'd2;
  localparam logic [2:0] RES_BAD     = 3'd3;
  localparam logic [2:0] RES_LEN     = 3'd4;

  typedef struct packed {
    logic       load;
    logic       cfg_wr;
    logic       start;
    logic [2:0] op;
    logic       hint_idxm1;
    logic [2:0] res;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic s_ge_top;
    logic fit;
    logic bit_lt_top;
    logic range_ok;
    logic head_ok;
    logic idx_lt_hint;
    logic idx_le2;
  } sts_t;

endpackage

// ===== design/bra_ctrl.sv =====
// Sequencer for the bitmap range allocator: handshakes and operation steps.
// Depends on bra_pkg; drives bra_dp through cmd_t and reads sts_t.
module bra_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bra_pkg::KIND_W-1:0]    kind,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  bra_pkg::sts_t                 sts,
  output bra_pkg::cmd_t                 cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_INIT_W = 4'd1;
  localparam logic [3:0] S_IDLE   = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_A_BIT  = 4'd4;
  localparam logic [3:0] S_A_CLR  = 4'd5;
  localparam logic [3:0] S_A_FILL = 4'd6;
  localparam logic [3:0] S_H_CHK  = 4'd7;
  localparam logic [3:0] S_H_WAIT = 4'd8;
  localparam logic [3:0] S_R_WAIT = 4'd9;
  localparam logic [3:0] S_F_DOWN = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]                  state, state_next;
  logic [2:0]                  res_code, res_code_next;
  logic [bra_pkg::KIND_W-1:0]  kind_r, kind_r_next;
  logic                        out_valid_next;
  logic                        out_free;

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    res_code_next  = res_code;
    kind_r_next    = kind_r;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    case (state)
      S_INIT: begin
        cmd.start  = 1'b1;
        cmd.op     = bra_pkg::OP_INIT;
        state_next = S_INIT_W;
      end
      S_INIT_W: begin
        if (sts.done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == bra_pkg::CFG_RESERVED || cfg_index == bra_pkg::CFG_USABLE) begin
            cmd.cfg_wr = 1'b1;
            state_next = S_INIT;
          end
        end else if (in_valid) begin
          cmd.load    = 1'b1;
          kind_r_next = kind;
          case (kind)
            bra_pkg::KIND_ALLOC: state_next = S_A_CHK;
            bra_pkg::KIND_FREE:  state_next = S_H_CHK;
            bra_pkg::KIND_SIZE:  state_next = S_H_CHK;
            default: begin
              res_code_next = bra_pkg::RES_BAD;
              state_next    = S_OUT;
            end
          endcase
        end
      end
      S_A_CHK: begin
        if (sts.s_ge_top) begin
          res_code_next = bra_pkg::RES_NOSPACE;
          state_next    = S_OUT;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = bra_pkg::OP_NEXT_SET;
          state_next = S_A_BIT;
        end
      end
      S_A_BIT: begin
        if (sts.done) begin
          if (sts.fit) begin
            cmd.start  = 1'b1;
            cmd.op     = bra_pkg::OP_FILL;
            state_next = S_A_FILL;
          end else if (sts.bit_lt_top) begin
            cmd.start  = 1'b1;
            cmd.op     = bra_pkg::OP_NEXT_CLR;
            state_next = S_A_CLR;
          end else begin
            res_code_next = bra_pkg::RES_NOSPACE;
            state_next    = S_OUT;
          end
        end
      end
      S_A_CLR: begin
        if (sts.done) state_next = S_A_CHK;
      end
      S_A_FILL: begin
        if (sts.done) begin
          res_code_next = bra_pkg::RES_ALLOC;
          state_next    = S_OUT;
        end
      end
      S_H_CHK: begin
        if (sts.range_ok) begin
          cmd.start  = 1'b1;
          cmd.op     = bra_pkg::OP_HEAD;
          state_next = S_H_WAIT;
        end else begin
          res_code_next = bra_pkg::RES_BAD;
          state_next    = S_OUT;
        end
      end
      S_H_WAIT: begin
        if (sts.done) begin
          if (sts.head_ok) begin
            cmd.start  = 1'b1;
            cmd.op     = (kind_r == bra_pkg::KIND_SIZE) ? bra_pkg::OP_RUN : bra_pkg::OP_FREE;
            state_next = S_R_WAIT;
          end else begin
            res_code_next = bra_pkg::RES_BAD;
            state_next    = S_OUT;
          end
        end
      end
      S_R_WAIT: begin
        if (sts.done) begin
          res_code_next = bra_pkg::RES_LEN;
          state_next    = S_OUT;
          // a free below the hint pulls the hint down
          if (kind_r == bra_pkg::KIND_FREE && sts.idx_lt_hint) begin
            if (sts.idx_le2) begin
              cmd.hint_idxm1 = 1'b1;
            end else begin
              cmd.start  = 1'b1;
              cmd.op     = bra_pkg::OP_DOWN;
              state_next = S_F_DOWN;
            end
          end
        end
      end
      S_F_DOWN: begin
        if (sts.done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.res        = res_code;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      res_code  <= bra_pkg::RES_NONE;
      kind_r    <= bra_pkg::KIND_ALLOC;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      res_code  <= res_code_next;
      kind_r    <= kind_r_next;
    end
  end

endmodule

// ===== design/bra_dp.sv =====
// Datapath of the bitmap range allocator: bitmap word memory, word scanner,
// hint, operand and result registers. Depends on bra_pkg; driven by bra_ctrl.
module bra_dp #(
  parameter int SLOTS = bra_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bra_pkg::cmd_t                  cmd,
  output bra_pkg::sts_t                  sts,
  input  logic [bra_pkg::COUNT_W-1:0]    count,
  input  logic [bra_pkg::COUNT_W-1:0]    align,
  input  logic [bra_pkg::SLOT_W-1:0]     slot_index,
  input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [bra_pkg::STAT_W-1:0]     status,
  output logic [bra_pkg::SLOT_W-1:0]     start_slot,
  output logic [bra_pkg::LEN_W-1:0]      run_length
);

  localparam int WORD   = bra_pkg::WORD;
  localparam int WB     = $clog2(WORD);
  localparam int NWORDS = (SLOTS + WORD - 1) / WORD;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int TW     = $clog2(SLOTS + 1);
  // positions plus alignment and count overshoot
  localparam int PW     = $clog2(SLOTS + 4096) + 1;
  localparam int CW     = bra_pkg::COUNT_W;

  logic [bra_pkg::SLOT_W-1:0] reserved_r;
  logic [CW-1:0]              usable_r;
  logic [PW-1:0]              top_p, res_p;

  logic [TW-1:0]              hint, bitp, len;
  logic [PW-1:0]              s;
  logic [CW-1:0]              nr, al;
  logic [bra_pkg::SLOT_W-1:0] idx;
  logic [PW-1:0]              nr_p, al_p, idx_p, bit_p;

  logic [WORD-1:0]            mem [NWORDS];
  logic [WORD-1:0]            rdata, wdata;
  logic                       we;

  logic                       sc_busy, sc_ev, sc_done;
  logic [2:0]                 sc_op;
  logic [AW-1:0]              sc_w;
  logic [PW-1:0]              sc_lo, sc_hi;

  logic [PW-1:0]              st_lo, st_hi;
  logic                       st_empty, st_fin;
  logic [PW-1:0]              base;
  logic [WORD-1:0]            m_up, m_dn, hits, low_bits;
  logic [WB-1:0]              lo_idx, hi_idx;
  logic                       found, ev_last, ev_act;
  logic [PW-1:0]              ev_pos;
  logic                       fin, fin_found;
  logic [2:0]                 fin_op;
  logic [PW-1:0]              fin_pos;

  function automatic logic [WORD-1:0] span(input logic [PW-1:0] b,
                                           input logic [PW-1:0] lo,
                                           input logic [PW-1:0] hi);
    logic [WB:0]   lo_o, hi_o;
    logic [PW-1:0] dl, dh;
    logic [WORD:0] bl, bh;
    dl = lo - b;
    dh = hi - b;
    if (lo <= b) lo_o = '0;
    else if (dl >= PW'(WORD)) lo_o = (WB+1)'(WORD);
    else lo_o = dl[WB:0];
    if (hi <= b) hi_o = '0;
    else if (dh >= PW'(WORD)) hi_o = (WB+1)'(WORD);
    else hi_o = dh[WB:0];
    bl = ~({(WORD+1){1'b1}} << lo_o);
    bh = ~({(WORD+1){1'b1}} << hi_o);
    return bh[WORD-1:0] & ~bl[WORD-1:0];
  endfunction

  // effective limits
  always_comb begin
    top_p = PW'(usable_r);
    if (top_p > PW'(SLOTS)) top_p = PW'(SLOTS);
    if (top_p < PW'(2)) top_p = PW'(2);
    res_p = PW'(reserved_r);
    if (res_p < PW'(1)) res_p = PW'(1);
    if (res_p > top_p - PW'(1)) res_p = top_p - PW'(1);
  end

  assign nr_p  = PW'(nr);
  assign al_p  = PW'(al);
  assign idx_p = PW'(idx);
  assign bit_p = PW'(bitp);

  // scan bounds at launch
  always_comb begin
    st_lo = '0;
    st_hi = top_p;
    case (cmd.op)
      bra_pkg::OP_INIT:     st_hi = res_p;
      bra_pkg::OP_NEXT_SET: st_lo = s + PW'(1);
      bra_pkg::OP_NEXT_CLR: st_lo = bit_p + PW'(1);
      bra_pkg::OP_HEAD:     st_lo = idx_p - PW'(1);
      bra_pkg::OP_RUN:      st_lo = idx_p + PW'(1);
      bra_pkg::OP_FREE:     st_lo = idx_p;
      bra_pkg::OP_FILL: begin
        st_lo = s;
        st_hi = s + nr_p;
      end
      bra_pkg::OP_DOWN:     st_lo = idx_p - PW'(2);
      default:              st_lo = '0;
    endcase
  end

  assign st_empty = (cmd.op != bra_pkg::OP_INIT) && (cmd.op != bra_pkg::OP_DOWN) &&
                    (st_lo >= st_hi);
  assign st_fin   = cmd.start && st_empty;

  // word evaluation
  assign base = PW'(sc_w) << WB;
  assign m_up = span(base, sc_lo, sc_hi);
  assign m_dn = span(base, '0, sc_lo + PW'(1));

  always_comb begin
    case (sc_op)
      bra_pkg::OP_NEXT_SET,
      bra_pkg::OP_HEAD:     hits = rdata & m_up;
      bra_pkg::OP_NEXT_CLR,
      bra_pkg::OP_RUN,
      bra_pkg::OP_FREE:     hits = ~rdata & m_up;
      bra_pkg::OP_DOWN:     hits = rdata & m_dn;
      default:              hits = '0;
    endcase
  end

  always_comb begin
    lo_idx = '0;
    for (int i = WORD - 1; i >= 0; i--) begin
      if (hits[i]) lo_idx = WB'(i);
    end
  end

  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < WORD; i++) begin
      if (hits[i]) hi_idx = WB'(i);
    end
  end

  assign found    = |hits;
  assign low_bits = ~({WORD{1'b1}} << lo_idx);
  assign ev_act   = sc_busy && sc_ev;

  always_comb begin
    if (!found) ev_pos = sc_hi;
    else if (sc_op == bra_pkg::OP_DOWN) ev_pos = base + PW'(hi_idx);
    else ev_pos = base + PW'(lo_idx);
    case (sc_op)
      bra_pkg::OP_DOWN: ev_last = found || (sc_w == '0);
      bra_pkg::OP_INIT: ev_last = (sc_w == AW'(NWORDS - 1));
      default:          ev_last = found || (base + PW'(WORD) >= sc_hi);
    endcase
    case (sc_op)
      bra_pkg::OP_FREE: wdata = rdata & ~(found ? (m_up & low_bits) : m_up);
      bra_pkg::OP_FILL: wdata = rdata | m_up;
      bra_pkg::OP_INIT: wdata = m_up;
      default:          wdata = rdata;
    endcase
  end

  assign we = ev_act && (sc_op == bra_pkg::OP_FREE || sc_op == bra_pkg::OP_FILL ||
                         sc_op == bra_pkg::OP_INIT);

  assign fin       = st_fin || (ev_act && ev_last);
  assign fin_op    = st_fin ? cmd.op : sc_op;
  assign fin_pos   = st_fin ? st_hi : ev_pos;
  assign fin_found = !st_fin && found;

  always_ff @(posedge clk) begin
    if (we) mem[sc_w] <= wdata;
    rdata <= mem[sc_w];
  end

  // scanner control: a read step then an evaluate step for each word
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_busy <= 1'b0;
      sc_ev   <= 1'b0;
      sc_done <= 1'b0;
    end else begin
      sc_done <= fin;
      if (cmd.start && !st_empty) begin
        sc_busy <= 1'b1;
        sc_ev   <= 1'b0;
      end else if (sc_busy) begin
        if (!sc_ev) sc_ev <= 1'b1;
        else begin
          sc_ev <= 1'b0;
          if (ev_last) sc_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sc_op <= cmd.op;
      sc_lo <= st_lo;
      sc_hi <= st_hi;
      sc_w  <= (cmd.op == bra_pkg::OP_INIT) ? '0 : st_lo[WB +: AW];
    end else if (ev_act && !ev_last) begin
      sc_w <= (sc_op == bra_pkg::OP_DOWN) ? sc_w - AW'(1) : sc_w + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_r <= bra_pkg::SLOT_W'(1);
      usable_r   <= CW'(1024);
    end else if (cmd.cfg_wr) begin
      case (cfg_index)
        bra_pkg::CFG_RESERVED: reserved_r <= cfg_data[bra_pkg::SLOT_W-1:0];
        bra_pkg::CFG_USABLE:   usable_r   <= cfg_data;
        default:               usable_r   <= usable_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nr  <= (count == '0) ? CW'(1) : count;
      al  <= (align == '0) ? CW'(1) : (align & (~align + CW'(1)));
      idx <= slot_index;
      s   <= PW'(hint);
    end
    if (cmd.start) begin
      case (cmd.op)
        bra_pkg::OP_INIT:     hint <= TW'(res_p);
        bra_pkg::OP_NEXT_SET: s <= (s + al_p) & ~(al_p - PW'(1));
        bra_pkg::OP_FILL: begin
          if (s <= PW'(hint) + PW'(2)) hint <= TW'(s + nr_p);
        end
        default: ;
      endcase
    end
    if (cmd.hint_idxm1) hint <= TW'(idx_p - PW'(1));
    if (fin) begin
      case (fin_op)
        bra_pkg::OP_NEXT_SET,
        bra_pkg::OP_HEAD:     bitp <= TW'(fin_pos);
        bra_pkg::OP_NEXT_CLR: s <= fin_pos;
        bra_pkg::OP_RUN,
        bra_pkg::OP_FREE:     len <= TW'(fin_pos - idx_p);
        bra_pkg::OP_DOWN:     hint <= fin_found ? TW'(fin_pos + PW'(1)) : TW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      bra_pkg::RES_ALLOC: begin
        status     <= bra_pkg::STAT_OK;
        start_slot <= bra_pkg::SLOT_W'(s);
        run_length <= '0;
      end
      bra_pkg::RES_NOSPACE: begin
        status     <= bra_pkg::STAT_NOSPACE;
        start_slot <= '0;
        run_length <= '0;
      end
      bra_pkg::RES_BAD: begin
        status     <= bra_pkg::STAT_BADIDX;
        start_slot <= '0;
        run_length <= '0;
      end
      bra_pkg::RES_LEN: begin
        status     <= bra_pkg::STAT_OK;
        start_slot <= '0;
        run_length <= bra_pkg::LEN_W'(len);
      end
      default: ;
    endcase
  end

  assign sts.done        = sc_done;
  assign sts.s_ge_top    = (s >= top_p);
  assign sts.bit_lt_top  = (bit_p < top_p);
  assign sts.fit         = (bit_p < top_p) ? (s + nr_p < bit_p) : (s + nr_p <= bit_p);
  assign sts.range_ok    = (idx_p >= res_p) && (idx_p < top_p);
  assign sts.head_ok     = (idx_p >= res_p) && (idx_p < top_p) && (bit_p == idx_p);
  assign sts.idx_lt_hint = (idx_p < PW'(hint));
  assign sts.idx_le2     = (idx_p <= PW'(2));

endmodule

// ===== design/bitmap_range_allocator_top.sv =====
// Bitmap first-fit range allocator over SLOTS slots, kept as 32-slot words in a
// single-port memory that is read one word at a time (read, then evaluate).
// An allocate scans words for each candidate start and then marks the words of
// its grant; a free or size query scans the words of the run, plus a downward
// word scan when a free lowers the hint. After reset and after each write of
// reserved_slots or usable_slots a fill pass rebuilds the map, during which no
// item is taken. One item is worked on at a time; the next may be accepted
// while a result still waits in the output register.
module bitmap_range_allocator_top #(
  parameter int SLOTS = bra_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bra_pkg::KIND_W-1:0]     kind,
  input  logic [bra_pkg::COUNT_W-1:0]    count,
  input  logic [bra_pkg::COUNT_W-1:0]    align,
  input  logic [bra_pkg::SLOT_W-1:0]     slot_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bra_pkg::STAT_W-1:0]     status,
  output logic [bra_pkg::SLOT_W-1:0]     start_slot,
  output logic [bra_pkg::LEN_W-1:0]      run_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data
);

  bra_pkg::cmd_t cmd;
  bra_pkg::sts_t sts;

  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd)
  );

  bra_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .count      (count),
    .align      (align),
    .slot_index (slot_index),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .start_slot (start_slot),
    .run_length (run_length)
  );

endmodule

// ===== design/bra_checker.sv =====
// Port-level checks for the bitmap range allocator, bound to the top level.
// Depends on bra_pkg and bitmap_range_allocator_top_defines.svh.
`include "bitmap_range_allocator_top_defines.svh"

module bra_props (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [bra_pkg::KIND_W-1:0]     kind,
  input logic [bra_pkg::COUNT_W-1:0]    count,
  input logic [bra_pkg::COUNT_W-1:0]    align,
  input logic [bra_pkg::SLOT_W-1:0]     slot_index,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bra_pkg::STAT_W-1:0]     status,
  input logic [bra_pkg::SLOT_W-1:0]     start_slot,
  input logic [bra_pkg::LEN_W-1:0]      run_length,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bra_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a held beat keeps its payload
  `BRA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(start_slot) && $stable(run_length), "result beat changed while stalled")

  // failures carry no slot and no length
  `BRA_ASSERT_NOW(a_fail_zero, out_valid && status != bra_pkg::STAT_OK, start_slot == '0 && run_length == '0, "failed result has nonzero fields")

  // a grant never reports a run length
  `BRA_ASSERT_NOW(a_grant_len, out_valid && status == bra_pkg::STAT_OK && start_slot != '0, run_length == '0, "grant with run length")

  // a register write starts the map rebuild, so items are held off
  `BRA_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready && (cfg_index == bra_pkg::CFG_RESERVED || cfg_index == bra_pkg::CFG_USABLE), in_stall, "item taken during map rebuild")

endmodule

bind bitmap_range_allocator_top bra_props u_bra_props (.*);

// ===== sim/bra_checker.sv =====
`timescale 1ns / 100ps
// Watches the item, result and register channels of the bitmap range allocator,
// keeps its own occupancy map and hint, and compares every result beat in order.
// Depends on bra_pkg for widths and codes.
module bra_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [bra_pkg::KIND_W-1:0]     kind,
  input  logic [bra_pkg::COUNT_W-1:0]    count,
  input  logic [bra_pkg::COUNT_W-1:0]    align,
  input  logic [bra_pkg::SLOT_W-1:0]     slot_index,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [bra_pkg::STAT_W-1:0]     status,
  input  logic [bra_pkg::SLOT_W-1:0]     start_slot,
  input  logic [bra_pkg::LEN_W-1:0]      run_length,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);

  localparam int NSLOT = bra_pkg::SLOTS_DEF;

  typedef struct packed {
    logic [bra_pkg::STAT_W-1:0] st;
    logic [bra_pkg::SLOT_W-1:0] start;
    logic [bra_pkg::LEN_W-1:0]  len;
  } grant_t;

  logic [9:0]  reg_reserved;
  logic [10:0] reg_usable;
  bit          occ [NSLOT];
  int          hint;
  grant_t      pending_results[$];

  assign pending = pending_results.size();

  function automatic int top_slot();
    int t;
    t = reg_usable;
    if (t > NSLOT) t = NSLOT;
    if (t < 2) t = 2;
    return t;
  endfunction

  function automatic int reserved_count();
    int r;
    r = reg_reserved;
    if (r < 1) r = 1;
    if (r > top_slot() - 1) r = top_slot() - 1;
    return r;
  endfunction

  function automatic bit is_set(int i);
    return i >= 0 && i < NSLOT && occ[i];
  endfunction

  function automatic int first_set(int from, int lim);
    for (int i = from; i < lim; i++) if (occ[i]) return i;
    return lim;
  endfunction

  function automatic int first_clear(int from, int lim);
    for (int i = from; i < lim; i++) if (!occ[i]) return i;
    return lim;
  endfunction

  function automatic bit starts_run(int idx);
    if (idx < reserved_count() || idx >= top_slot()) return 0;
    return is_set(idx) && !is_set(idx - 1);
  endfunction

  function automatic void rebuild_map();
    int r;
    r = reserved_count();
    for (int i = 0; i < NSLOT; i++) occ[i] = (i < r);
    hint = r;
  endfunction

  // updates the map and returns the result one item produces
  function automatic grant_t apply_item(logic [bra_pkg::KIND_W-1:0] k, int nr, int al,
                                        int idx);
    grant_t g;
    int     lim, s, nb, b;
    lim = top_slot();
    g   = '{st: bra_pkg::STAT_BADIDX, start: '0, len: '0};
    if (k == bra_pkg::KIND_ALLOC) begin
      if (nr == 0) nr = 1;
      al = (al == 0) ? 1 : (al & -al);
      s = hint;
      while (s < lim) begin
        nb = first_set(s + 1, lim);
        s = (s + al) & ~(al - 1);
        if (nb < lim) begin
          if (s + nr < nb) break;
          s = first_clear(nb + 1, lim);
        end else begin
          if (s + nr <= nb) break;
          s = nb;
        end
      end
      if (s < lim) begin
        for (int i = s; i < s + nr && i < NSLOT; i++) occ[i] = 1;
        if (s <= hint + 2) hint = s + nr;
        g.st    = bra_pkg::STAT_OK;
        g.start = s[bra_pkg::SLOT_W-1:0];
      end else begin
        g.st = bra_pkg::STAT_NOSPACE;
      end
    end else if (k == bra_pkg::KIND_FREE) begin
      if (starts_run(idx)) begin
        b = idx;
        if (b < hint) begin
          hint = b - 1;
          while (hint > 1 && !is_set(hint - 1)) hint--;
        end
        while (b < lim && occ[b]) begin
          occ[b] = 0;
          b++;
        end
        g.st  = bra_pkg::STAT_OK;
        g.len = bra_pkg::LEN_W'(b - idx);
      end
    end else if (k == bra_pkg::KIND_SIZE) begin
      if (starts_run(idx)) begin
        g.st  = bra_pkg::STAT_OK;
        g.len = bra_pkg::LEN_W'(first_clear(idx + 1, lim) - idx);
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      reg_reserved = 10'd1;
      reg_usable   = 11'd1024;
      rebuild_map();
      pending_results.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bra_pkg::CFG_RESERVED) reg_reserved = cfg_data[9:0];
        else if (cfg_index == bra_pkg::CFG_USABLE) reg_usable = cfg_data;
        if (cfg_index == bra_pkg::CFG_RESERVED || cfg_index == bra_pkg::CFG_USABLE)
          rebuild_map();
      end
      if (in_valid && !in_stall)
        pending_results.push_back(apply_item(kind, count, align, slot_index));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d start %0d len %0d",
                   $time, status, start_slot, run_length);
          errors <= errors + 1;
        end else begin
          want = pending_results.pop_front();
          if (want.st !== status || want.start !== start_slot || want.len !== run_length) begin
            $display("%0t: mismatch: expected status %0d start %0d len %0d, got %0d %0d %0d",
                     $time, want.st, want.start, want.len, status, start_slot, run_length);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for bitmap_range_allocator_top: register phases, directed
// and random items, random stalls. Depends on bra_pkg and bra_checker.
module testbench;

  localparam int IDLE_LIMIT = 20000;
  localparam int NPHASE     = 6;
  // kind code with no operation behind it
  localparam logic [bra_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RES_VAL [NPHASE] = '{1, 1023, 1, 37, 5, 1};
  localparam int USE_VAL [NPHASE] = '{1024, 1024, 2, 300, 64, 1024};
  localparam int N_ITEMS [NPHASE] = '{240, 100, 40, 300, 250, 300};

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [bra_pkg::KIND_W-1:0]     kind = bra_pkg::KIND_ALLOC;
  logic [bra_pkg::COUNT_W-1:0]    count = '0;
  logic [bra_pkg::COUNT_W-1:0]    align = '0;
  logic [bra_pkg::SLOT_W-1:0]     slot_index = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [bra_pkg::STAT_W-1:0]     status;
  logic [bra_pkg::SLOT_W-1:0]     start_slot;
  logic [bra_pkg::LEN_W-1:0]      run_length;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index = bra_pkg::CFG_RESERVED;
  logic [bra_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                             errors, pending;

  bit                          no_gaps;
  int                          stall_left;
  int                          idle_cycles;
  logic [bra_pkg::KIND_W-1:0]  kinds_sent[$];
  int                          live_runs[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bitmap_range_allocator_top dut (.*);

  bra_checker chk (.*);

  // result-side stall; also collects granted starts for later frees
  always @(posedge clk) begin
    int nh;
    logic [bra_pkg::KIND_W-1:0] k;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      nh = stall_left;
      if (out_valid && !out_stall) begin
        nh = no_gaps ? 0 : $urandom_range(0, 18);
        if (kinds_sent.size() > 0) begin
          k = kinds_sent.pop_front();
          if (k == bra_pkg::KIND_ALLOC && status == bra_pkg::STAT_OK)
            live_runs.push_back(start_slot);
        end
      end else if (nh > 0) begin
        nh--;
      end
      stall_left <= nh;
      out_stall  <= (nh != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(logic [bra_pkg::KIND_W-1:0] k, int c, int a, int idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind       <= k;
    count      <= bra_pkg::COUNT_W'(c);
    align      <= bra_pkg::COUNT_W'(a);
    slot_index <= bra_pkg::SLOT_W'(idx);
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    kinds_sent.push_back(k);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [bra_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_index <= idx;
    cfg_data  <= bra_pkg::CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_align();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 4;
      4: return 1 << $urandom_range(3, 10);
      default: return $urandom_range(0, 1024);
    endcase
  endfunction

  function automatic int take_live(bit remove);
    int p, v;
    if (live_runs.size() == 0) return $urandom_range(0, 1023);
    p = $urandom_range(0, live_runs.size() - 1);
    v = live_runs[p];
    if (remove) live_runs.delete(p);
    return v;
  endfunction

  task automatic random_item();
    int r, c;
    r = $urandom_range(0, 99);
    if (r < 55 || (r < 92 && live_runs.size() == 0)) begin
      c = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 12);
      if ($urandom_range(0, 99) == 0) c = 1024;
      send(bra_pkg::KIND_ALLOC, c, pick_align(), $urandom_range(0, 1023));
    end else if (r < 80) begin
      send(bra_pkg::KIND_FREE, $urandom_range(0, 2047), $urandom_range(0, 2047),
           take_live(1));
    end else if (r < 92) begin
      send(bra_pkg::KIND_SIZE, $urandom_range(0, 2047), $urandom_range(0, 2047),
           take_live(0));
    end else if (r < 98) begin
      send(r[0] ? bra_pkg::KIND_FREE : bra_pkg::KIND_SIZE, 0, 0, $urandom_range(0, 1023));
    end else begin
      send(KIND_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 2047),
           $urandom_range(0, 1023));
    end
  endtask

  initial begin
    int v;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings
    send(bra_pkg::KIND_ALLOC, 0, 0, 0);
    send(bra_pkg::KIND_ALLOC, 3, 6, 0);
    send(bra_pkg::KIND_ALLOC, 1024, 1, 0);
    send(bra_pkg::KIND_ALLOC, 5, 1024, 1023);
    send(bra_pkg::KIND_ALLOC, 7, 3, 0);
    send(bra_pkg::KIND_ALLOC, 2, 16, 0);
    send(KIND_UNUSED, 2047, 2047, 1023);
    drain();
    v = live_runs[1];
    send(bra_pkg::KIND_SIZE, 0, 0, v);
    send(bra_pkg::KIND_SIZE, 0, 0, v + 1);
    send(bra_pkg::KIND_FREE, 0, 0, v + 1);
    send(bra_pkg::KIND_FREE, 0, 0, 0);
    send(bra_pkg::KIND_SIZE, 0, 0, 1023);
    send(bra_pkg::KIND_FREE, 0, 0, live_runs[0]);
    send(bra_pkg::KIND_FREE, 0, 0, live_runs[0]);
    send(bra_pkg::KIND_FREE, 0, 0, v);
    send(bra_pkg::KIND_ALLOC, 1, 0, 0);
    send(bra_pkg::KIND_ALLOC, 1023, 0, 0);
    live_runs.delete();
    drain();

    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph > 0) begin
        write_reg(bra_pkg::CFG_RESERVED, RES_VAL[ph]);
        write_reg(bra_pkg::CFG_USABLE, USE_VAL[ph]);
        live_runs.delete();
      end
      for (int i = 0; i < N_ITEMS[ph]; i++) begin
        if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (i == N_ITEMS[ph] / 2) drain();
        random_item();
      end
      drain();
    end
    no_gaps = 1'b0;
    repeat (100) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
